@@ rtl/assert_macros.svh @@
// Assertion macros used by the price level book datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define PLB_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition on one edge implies a condition on the next edge.
`define PLB_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

@@ rtl/plb_pkg.sv @@
// Package for the price level book: sizes, codes, payload and control types.
package plb_pkg;

    localparam int MAX_SECURITIES = 64;
    localparam int MAX_DEPTH      = 10;

    localparam int SLOT_W = (MAX_SECURITIES > 1) ? $clog2(MAX_SECURITIES) : 1;
    localparam int SCAN_W = SLOT_W + 1;
    localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
    localparam int LA_W   = (2 * MAX_SECURITIES * MAX_DEPTH > 1) ?
                            $clog2(2 * MAX_SECURITIES * MAX_DEPTH) : 1;

    // Result status codes
    localparam logic [2:0] STS_DISCARD  = 3'd0;
    localparam logic [2:0] STS_RESET    = 3'd1;
    localparam logic [2:0] STS_UPDATED  = 3'd2;
    localparam logic [2:0] STS_REJECTED = 3'd3;
    localparam logic [2:0] STS_TRADE    = 3'd4;
    localparam logic [2:0] STS_DEF_DONE = 3'd5;
    localparam logic [2:0] STS_FULL     = 3'd6;

    // Entry types
    localparam logic [2:0] ET_BID     = 3'd0;
    localparam logic [2:0] ET_OFFER   = 3'd1;
    localparam logic [2:0] ET_TRADE   = 3'd2;
    localparam logic [2:0] ET_RESET   = 3'd3;
    localparam logic [2:0] ET_IMPLIED = 3'd4;

    // Update kinds
    localparam logic [2:0] UK_NEW     = 3'd0;
    localparam logic [2:0] UK_CHANGE  = 3'd1;
    localparam logic [2:0] UK_DELETE  = 3'd2;
    localparam logic [2:0] UK_DELTHRU = 3'd3;
    localparam logic [2:0] UK_DELFROM = 3'd4;
    localparam logic [2:0] UK_INVALID = 3'd5;

    // Message kinds
    localparam logic [1:0] MK_RECOVERY = 2'd0;
    localparam logic [1:0] MK_INCR     = 2'd1;

    localparam logic ACT_DEFINITION = 1'b0;
    localparam logic ACT_BOOK       = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] instrument_id;
        logic        remove_instrument;
        logic [7:0]  book_depth;
        logic [1:0]  message_kind;
        logic [2:0]  entry_type;
        logic [2:0]  update_kind;
        logic [7:0]  price_level;
        logic [30:0] order_count;
        logic [30:0] entry_quantity;
        logic signed [63:0] entry_price;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        side;
        logic [3:0]  level_index;
        logic [30:0] level_orders;
        logic [30:0] level_quantity;
        logic signed [63:0] level_price;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [30:0] orders;
        logic [30:0] quantity;
        logic [63:0] price;
    } level_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DISPATCH,
        S_DEF_RD,
        S_DEF_WR,
        S_UPD_RD,
        S_UPD_CHK,
        S_MOVE,
        S_MOVE_WR,
        S_SET,
        S_CNT_WR,
        S_EM_RD,
        S_EM_OUT,
        S_RESP
    } plb_state_t;

    typedef struct packed {
        logic       in_load;
        logic       scan_step;
        logic       slot_clear;
        logic       slot_create;
        logic       depth_write;
        logic       book_clear;
        logic       resp_load;
        logic [2:0] resp_status;
        logic       resp_side;
        logic       resp_input;
        logic       upd_read;
        logic       plan_load;
        logic       fill_write;
        logic       move_read;
        logic       move_write;
        logic       set_write;
        logic       cnt_write;
        logic       emit_read;
        logic       emit_load;
        logic       def_sc_read;
        logic       def_sc_write;
        logic       side_next;
        logic       resp_out;
    } plb_cmd_t;

    typedef struct packed {
        logic       scan_done;
        logic       found;
        logic       free_found;
        logic       action;
        logic       remove;
        logic [2:0] etype;
        logic       plan_reject;
        logic       move_left;
        logic       move_fill;
        logic       plan_set;
        logic       cnt_zero;
        logic       emit_last;
        logic       out_free;
        logic       def_side;
    } plb_stat_t;

endpackage

@@ rtl/price_level_book_builder.sv @@
// Top level of the price level book builder.
//
// Input channel item/item_valid/item_ready carries one request: an instrument
// definition or a book entry message. Output channel result/result_valid/
// result_ready carries one or more results per request; the final one has
// last set. Requests are handled one at a time.
// Every request first searches the slot table, one slot per cycle, then is
// dispatched. A definition of a known instrument then reads and trims the
// count of each side. A definition, reset, trade, discarded or rejected
// entry gives a single result. An applied update shifts or zero-fills
// levels, writes the new level and the side count, then emits each level
// of the side, or a single result when the side is empty. With 64 slots
// and depth 10 the slot search dominates the time of a request.
// Reset clears all slots and all side counts at once; no clearing pass.
// A stalled receiver holds the result register; the block waits and accepts
// no new request until the last result of the current one is loaded.
module price_level_book_builder (
    input  logic               clk,
    input  logic               rst_n,
    input  plb_pkg::in_item_t  item,
    input  logic               item_valid,
    output logic               item_ready,
    output plb_pkg::out_item_t result,
    output logic               result_valid,
    input  logic               result_ready
);
    import plb_pkg::*;

    plb_cmd_t  cmd;
    plb_stat_t st;

    plb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .st         (st),
        .cmd        (cmd)
    );

    plb_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .st           (st),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

@@ rtl/plb_dp.sv @@
// Datapath: slot table, side counts, level store, update plan and result register.
`include "assert_macros.svh"

module plb_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  plb_pkg::in_item_t  item,
    input  plb_pkg::plb_cmd_t  cmd,
    output plb_pkg::plb_stat_t st,
    output plb_pkg::out_item_t result,
    output logic               result_valid,
    input  logic               result_ready
);
    import plb_pkg::*;

    in_item_t in_reg;

    // slot search
    logic [SCAN_W-1:0] scan_idx_reg;
    logic [SLOT_W-1:0] cmp_idx_reg;
    logic              cmp_live_reg;
    logic [31:0]       sec_q_reg;
    logic              found_reg;
    logic              free_found_reg;
    logic [SLOT_W-1:0] found_slot_reg;
    logic [SLOT_W-1:0] free_slot_reg;
    logic [MAX_SECURITIES-1:0] slot_valid_reg;

    logic [31:0]      sec_mem   [MAX_SECURITIES];
    logic [CNT_W-1:0] depth_mem [MAX_SECURITIES];
    logic [CNT_W-1:0] depth_q_reg;

    logic [CNT_W-1:0]          sc_mem [2*MAX_SECURITIES];
    logic [2*MAX_SECURITIES-1:0] sc_vld_reg;
    logic [CNT_W-1:0]          sc_q_reg;
    logic                      sc_qv_reg;

    level_t lvl_mem [2*MAX_SECURITIES*MAX_DEPTH];
    level_t lvl_q_reg;

    logic side_reg;

    // update plan
    logic [CNT_W-1:0] rem_reg, dst_reg, src_reg, new_cnt_reg, emit_idx_reg;
    logic             down_reg, fill_reg, set_reg;

    logic [2:0] resp_status_reg;
    logic       resp_side_reg;
    logic       resp_input_reg;

    out_item_t out_reg;
    logic      out_valid_reg;

    // combinational helpers
    logic [CNT_W-1:0]  clamp_depth, cnt_q, lv, lm1, top, kmin;
    logic              upd_side, out_free, emit_last, reject;
    logic [SLOT_W:0]   sc_upd, sc_def;
    logic [LA_W-1:0]   base;
    logic [8:0]        lvl9, dep9, cnt9;
    logic [2:0]        kind;
    logic [CNT_W-1:0]  p_rem, p_dst, p_src, p_new;
    logic              p_down, p_fill, p_set;
    logic [CNT_W:0]    emit_next;

    assign clamp_depth = (in_reg.book_depth > 8'(MAX_DEPTH)) ? CNT_W'(MAX_DEPTH)
                                                             : in_reg.book_depth[CNT_W-1:0];
    assign cnt_q     = sc_qv_reg ? sc_q_reg : '0;
    assign upd_side  = in_reg.entry_type[0];
    assign sc_upd    = {found_slot_reg, upd_side};
    assign sc_def    = {found_slot_reg, side_reg};
    assign base      = LA_W'(sc_upd) * LA_W'(MAX_DEPTH);
    assign out_free  = !out_valid_reg || result_ready;
    assign emit_next = {1'b0, emit_idx_reg} + 1'b1;
    assign emit_last = (emit_next == {1'b0, new_cnt_reg});

    // plan of one bid or offer update
    assign lvl9 = {1'b0, in_reg.price_level};
    assign dep9 = 9'(depth_q_reg);
    assign cnt9 = 9'(cnt_q);
    assign kind = (in_reg.message_kind == MK_RECOVERY) ? UK_NEW : in_reg.update_kind;
    assign lv   = in_reg.price_level[CNT_W-1:0];
    assign lm1  = lv - 1'b1;
    assign top  = (cnt_q < depth_q_reg) ? cnt_q : depth_q_reg - 1'b1;
    assign kmin = (lv < cnt_q) ? lv : cnt_q;

    always_comb
    begin
        reject = (in_reg.message_kind != MK_RECOVERY && in_reg.message_kind != MK_INCR) ||
                 (kind != UK_DELTHRU &&
                  (kind > UK_DELFROM || lvl9 == 9'd0 || lvl9 > dep9 ||
                   ((kind == UK_CHANGE || kind == UK_DELETE) && cnt9 < lvl9)));
    end

    always_comb
    begin
        p_rem  = '0;
        p_dst  = '0;
        p_src  = '0;
        p_new  = '0;
        p_down = 1'b0;
        p_fill = 1'b0;
        p_set  = 1'b0;
        case (kind)
            UK_NEW:
            begin
                p_set = 1'b1;
                if (lvl9 <= cnt9 + 9'd1)
                begin
                    // open a hole at the level, last level falls off at full depth
                    p_rem  = top - lm1;
                    p_dst  = top;
                    p_src  = top - 1'b1;
                    p_down = 1'b1;
                    p_new  = (cnt_q < depth_q_reg) ? cnt_q + 1'b1 : depth_q_reg;
                end
                else
                begin
                    // zero the gap below the new level
                    p_fill = 1'b1;
                    p_rem  = lm1 - cnt_q;
                    p_dst  = cnt_q;
                    p_src  = cnt_q;
                    p_new  = lv;
                end
            end
            UK_CHANGE:
            begin
                p_set = 1'b1;
                p_new = cnt_q;
            end
            UK_DELETE:
            begin
                p_rem = cnt_q - lv;
                p_dst = lm1;
                p_src = lv;
                p_new = cnt_q - 1'b1;
            end
            UK_DELFROM:
            begin
                p_rem = cnt_q - kmin;
                p_src = kmin;
                p_new = cnt_q - kmin;
            end
            default:
            begin
                p_new = '0;
            end
        endcase
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
            in_reg <= item;
    end

    // slot search, one slot per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            cmp_idx_reg    <= '0;
            cmp_live_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            found_slot_reg <= '0;
            free_slot_reg  <= '0;
        end
        else if (cmd.in_load)
        begin
            scan_idx_reg   <= '0;
            cmp_live_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (scan_idx_reg != SCAN_W'(MAX_SECURITIES))
            begin
                cmp_idx_reg  <= scan_idx_reg[SLOT_W-1:0];
                cmp_live_reg <= 1'b1;
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            else
                cmp_live_reg <= 1'b0;
            if (cmp_live_reg)
            begin
                if (!found_reg && slot_valid_reg[cmp_idx_reg] &&
                    sec_q_reg == in_reg.instrument_id)
                begin
                    found_reg      <= 1'b1;
                    found_slot_reg <= cmp_idx_reg;
                end
                if (!free_found_reg && !slot_valid_reg[cmp_idx_reg])
                begin
                    free_found_reg <= 1'b1;
                    free_slot_reg  <= cmp_idx_reg;
                end
            end
        end
    end

    // slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_valid_reg <= '0;
        else if (cmd.slot_clear && found_reg)
            slot_valid_reg[found_slot_reg] <= 1'b0;
        else if (cmd.slot_create)
            slot_valid_reg[free_slot_reg] <= 1'b1;
    end

    // security and depth memories
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
            sec_q_reg <= sec_mem[scan_idx_reg[SLOT_W-1:0]];
        if (cmd.slot_create)
            sec_mem[free_slot_reg] <= in_reg.instrument_id;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd_read)
            depth_q_reg <= depth_mem[found_slot_reg];
        if (cmd.slot_create)
            depth_mem[free_slot_reg] <= clamp_depth;
        else if (cmd.depth_write)
            depth_mem[found_slot_reg] <= clamp_depth;
    end

    // side counts: memory plus valid bits
    always_ff @(posedge clk)
    begin
        if (cmd.upd_read)
            sc_q_reg <= sc_mem[sc_upd];
        else if (cmd.def_sc_read)
            sc_q_reg <= sc_mem[sc_def];
        if (cmd.cnt_write)
            sc_mem[sc_upd] <= new_cnt_reg;
        else if (cmd.def_sc_write && cnt_q > clamp_depth)
            sc_mem[sc_def] <= clamp_depth;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_vld_reg <= '0;
            sc_qv_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.upd_read)
                sc_qv_reg <= sc_vld_reg[sc_upd];
            else if (cmd.def_sc_read)
                sc_qv_reg <= sc_vld_reg[sc_def];
            if (cmd.book_clear)
                sc_vld_reg <= '0;
            else if (cmd.slot_create)
            begin
                sc_vld_reg[{free_slot_reg, 1'b0}] <= 1'b0;
                sc_vld_reg[{free_slot_reg, 1'b1}] <= 1'b0;
            end
            else if (cmd.cnt_write)
                sc_vld_reg[sc_upd] <= 1'b1;
        end
    end

    // level store
    always_ff @(posedge clk)
    begin
        if (cmd.move_read)
            lvl_q_reg <= lvl_mem[base + LA_W'(src_reg)];
        else if (cmd.emit_read)
            lvl_q_reg <= lvl_mem[base + LA_W'(emit_idx_reg)];
        if (cmd.move_write)
            lvl_mem[base + LA_W'(dst_reg)] <= lvl_q_reg;
        else if (cmd.fill_write)
            lvl_mem[base + LA_W'(dst_reg)] <= '0;
        else if (cmd.set_write)
            lvl_mem[base + LA_W'(lm1)] <= {in_reg.order_count, in_reg.entry_quantity,
                                           in_reg.entry_price};
    end

    // plan counters, emit index, truncation side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg      <= '0;
            dst_reg      <= '0;
            src_reg      <= '0;
            new_cnt_reg  <= '0;
            emit_idx_reg <= '0;
            down_reg     <= 1'b0;
            fill_reg     <= 1'b0;
            set_reg      <= 1'b0;
            side_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.plan_load)
            begin
                rem_reg     <= p_rem;
                dst_reg     <= p_dst;
                src_reg     <= p_src;
                new_cnt_reg <= p_new;
                down_reg    <= p_down;
                fill_reg    <= p_fill;
                set_reg     <= p_set;
            end
            else if (cmd.move_write || cmd.fill_write)
            begin
                rem_reg <= rem_reg - 1'b1;
                dst_reg <= down_reg ? dst_reg - 1'b1 : dst_reg + 1'b1;
                src_reg <= down_reg ? src_reg - 1'b1 : src_reg + 1'b1;
            end
            if (cmd.cnt_write)
                emit_idx_reg <= '0;
            else if (cmd.emit_load)
                emit_idx_reg <= emit_idx_reg + 1'b1;
            if (cmd.depth_write)
                side_reg <= 1'b0;
            else if (cmd.side_next)
                side_reg <= 1'b1;
        end
    end

    // single-result response code
    always_ff @(posedge clk)
    begin
        if (cmd.resp_load)
        begin
            resp_status_reg <= cmd.resp_status;
            resp_side_reg   <= cmd.resp_side ? upd_side : 1'b0;
            resp_input_reg  <= cmd.resp_input;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.resp_out || cmd.emit_load)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resp_out)
        begin
            out_reg.status         <= resp_status_reg;
            out_reg.side           <= resp_side_reg;
            out_reg.level_index    <= '0;
            out_reg.level_orders   <= resp_input_reg ? in_reg.order_count : '0;
            out_reg.level_quantity <= resp_input_reg ? in_reg.entry_quantity : '0;
            out_reg.level_price    <= resp_input_reg ? in_reg.entry_price : '0;
            out_reg.last           <= 1'b1;
        end
        else if (cmd.emit_load)
        begin
            out_reg.status         <= STS_UPDATED;
            out_reg.side           <= upd_side;
            out_reg.level_index    <= 4'(emit_next);
            out_reg.level_orders   <= lvl_q_reg.orders;
            out_reg.level_quantity <= lvl_q_reg.quantity;
            out_reg.level_price    <= lvl_q_reg.price;
            out_reg.last           <= emit_last;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    // status to the controller
    always_comb
    begin
        st.scan_done   = cmp_live_reg && (cmp_idx_reg == SLOT_W'(MAX_SECURITIES - 1));
        st.found       = found_reg;
        st.free_found  = free_found_reg;
        st.action      = in_reg.action;
        st.remove      = in_reg.remove_instrument;
        st.etype       = in_reg.entry_type;
        st.plan_reject = reject;
        st.move_left   = (rem_reg != '0);
        st.move_fill   = fill_reg;
        st.plan_set    = set_reg;
        st.cnt_zero    = (new_cnt_reg == '0);
        st.emit_last   = emit_last;
        st.out_free    = out_free;
        st.def_side    = side_reg;
    end

    `PLB_ASSERT_CLK(a_cnt_in_depth, cmd.cnt_write |-> (new_cnt_reg <= depth_q_reg), "count > depth")
    `PLB_ASSERT_CLK(a_move_in_range, (cmd.move_write || cmd.fill_write) |-> (dst_reg < CNT_W'(MAX_DEPTH)), "bad level")
    `PLB_ASSERT_CLK(a_load_when_free, (cmd.resp_out || cmd.emit_load) |-> out_free, "result overwritten")

endmodule

@@ rtl/plb_ctrl.sv @@
// Controller: sequences search, definition, update, shifting and emission.
module plb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  plb_pkg::plb_stat_t st,
    output plb_pkg::plb_cmd_t  cmd
);
    import plb_pkg::*;

    plb_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (item_valid)
                    state_next = S_SCAN;
            S_SCAN:
                if (st.scan_done)
                    state_next = S_DISPATCH;
            S_DISPATCH:
                if (st.action == ACT_DEFINITION && !st.remove && st.found)
                    state_next = S_DEF_RD;
                else if (st.action != ACT_DEFINITION && st.etype != ET_RESET &&
                         st.found && st.etype < ET_TRADE)
                    state_next = S_UPD_RD;
                else
                    state_next = S_RESP;
            S_DEF_RD:
                state_next = S_DEF_WR;
            S_DEF_WR:
                state_next = st.def_side ? S_RESP : S_DEF_RD;
            S_UPD_RD:
                state_next = S_UPD_CHK;
            S_UPD_CHK:
                state_next = st.plan_reject ? S_RESP : S_MOVE;
            S_MOVE:
                if (!st.move_left)
                    state_next = st.plan_set ? S_SET : S_CNT_WR;
                else if (!st.move_fill)
                    state_next = S_MOVE_WR;
            S_MOVE_WR:
                state_next = S_MOVE;
            S_SET:
                state_next = S_CNT_WR;
            S_CNT_WR:
                state_next = st.cnt_zero ? S_RESP : S_EM_RD;
            S_EM_RD:
                state_next = S_EM_OUT;
            S_EM_OUT:
                if (st.out_free)
                    state_next = st.emit_last ? S_IDLE : S_EM_RD;
            S_RESP:
                if (st.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd        = '0;
        item_ready = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
                cmd.in_load = item_valid;
            S_SCAN:
                cmd.scan_step = 1'b1;
            S_DISPATCH:
            begin
                cmd.resp_load = 1'b1;
                if (st.action == ACT_DEFINITION)
                begin
                    cmd.resp_status = STS_DEF_DONE;
                    if (st.remove)
                        cmd.slot_clear = 1'b1;
                    else if (st.found)
                        cmd.depth_write = 1'b1;
                    else if (st.free_found)
                        cmd.slot_create = 1'b1;
                    else
                        cmd.resp_status = STS_FULL;
                end
                else if (st.etype == ET_RESET)
                begin
                    cmd.book_clear  = 1'b1;
                    cmd.resp_status = STS_RESET;
                end
                else if (!st.found || st.etype > ET_TRADE)
                    cmd.resp_status = STS_DISCARD;
                else if (st.etype == ET_TRADE)
                begin
                    cmd.resp_status = STS_TRADE;
                    cmd.resp_input  = 1'b1;
                end
            end
            S_DEF_RD:
                cmd.def_sc_read = 1'b1;
            S_DEF_WR:
            begin
                cmd.def_sc_write = 1'b1;
                cmd.side_next    = 1'b1;
            end
            S_UPD_RD:
                cmd.upd_read = 1'b1;
            S_UPD_CHK:
            begin
                cmd.plan_load   = !st.plan_reject;
                cmd.resp_load   = st.plan_reject;
                cmd.resp_status = STS_REJECTED;
                cmd.resp_side   = 1'b1;
            end
            S_MOVE:
                if (st.move_left)
                begin
                    cmd.fill_write = st.move_fill;
                    cmd.move_read  = !st.move_fill;
                end
            S_MOVE_WR:
                cmd.move_write = 1'b1;
            S_SET:
                cmd.set_write = 1'b1;
            S_CNT_WR:
            begin
                cmd.cnt_write   = 1'b1;
                cmd.resp_load   = st.cnt_zero;
                cmd.resp_status = STS_UPDATED;
                cmd.resp_side   = 1'b1;
            end
            S_EM_RD:
                cmd.emit_read = 1'b1;
            S_EM_OUT:
                cmd.emit_load = st.out_free;
            S_RESP:
                cmd.resp_out = st.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

@@ dv/testbench.sv @@
// Testbench for the price level book builder: random and directed requests, scoreboard check.
module testbench;
    import plb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 258;

    logic      clk;
    logic      rst_n;
    in_item_t  item;
    logic      item_valid;
    logic      item_ready;
    out_item_t result;
    logic      result_valid;
    logic      result_ready;

    price_level_book_builder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Shadow copy of the books
    logic        bk_valid [MAX_SECURITIES] = '{default: 1'b0};
    logic [31:0] bk_sec   [MAX_SECURITIES];
    int unsigned bk_depth [MAX_SECURITIES];
    int unsigned bk_cnt   [2*MAX_SECURITIES] = '{default: 0};
    level_t      bk_lvl   [2*MAX_SECURITIES][MAX_DEPTH];

    in_item_t  pending_requests[$];
    out_item_t expected_results[$];
    int        error_count;
    int        idle_cycles;
    int        sender_hold;
    int        receiver_hold;
    bit        stimulus_done;
    bit        long_stall_req;
    bit        drain_req;

    function automatic out_item_t make_result(logic [2:0] st, logic sd);
        out_item_t r;
        r = '0;
        r.status = st;
        r.side   = sd;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic int find_book(logic [31:0] sec);
        for (int s = 0; s < MAX_SECURITIES; s++)
            if (bk_valid[s] && bk_sec[s] == sec)
                return s;
        return -1;
    endfunction

    // Apply a bid/offer update to the shadow books; 1 when accepted, 0 when rejected
    function automatic bit apply_book_update(int slot, in_item_t it);
        int unsigned sc, depth, cnt, lvl, top, k;
        logic [2:0]  kind;
        level_t      nl;
        sc    = slot * 2 + it.entry_type[0];
        depth = bk_depth[slot];
        cnt   = bk_cnt[sc];
        lvl   = 32'(it.price_level);
        kind  = it.update_kind;
        nl.orders   = it.order_count;
        nl.quantity = it.entry_quantity;
        nl.price    = it.entry_price;
        if (it.message_kind == MK_RECOVERY)
            kind = UK_NEW;
        else if (it.message_kind != MK_INCR)
            return 0;
        if (kind == UK_DELTHRU)
        begin
            bk_cnt[sc] = 0;
            return 1;
        end
        if (kind > UK_DELFROM || lvl == 0 || lvl > depth)
            return 0;
        case (kind)
            UK_NEW:
            begin
                if (lvl <= cnt + 1)
                begin
                    top = (cnt < depth) ? cnt : depth - 1;
                    for (int i = top; i > lvl - 1; i--)
                        bk_lvl[sc][i] = bk_lvl[sc][i-1];
                    bk_lvl[sc][lvl-1] = nl;
                    cnt++;
                end
                else
                begin
                    for (int i = cnt; i < lvl - 1; i++)
                        bk_lvl[sc][i] = '0;
                    bk_lvl[sc][lvl-1] = nl;
                    cnt = lvl;
                end
                if (cnt > depth)
                    cnt = depth;
                bk_cnt[sc] = cnt;
            end
            UK_CHANGE:
            begin
                if (cnt < lvl)
                    return 0;
                bk_lvl[sc][lvl-1] = nl;
            end
            UK_DELETE:
            begin
                if (cnt < lvl)
                    return 0;
                for (int i = lvl - 1; i + 1 < cnt; i++)
                    bk_lvl[sc][i] = bk_lvl[sc][i+1];
                bk_cnt[sc] = cnt - 1;
            end
            default:
            begin
                k = (lvl < cnt) ? lvl : cnt;
                for (int i = 0; i + k < cnt; i++)
                    bk_lvl[sc][i] = bk_lvl[sc][i+k];
                bk_cnt[sc] = cnt - k;
            end
        endcase
        return 1;
    endfunction

    // Predict the results of one accepted request
    task automatic predict_book_results(in_item_t it);
        int          slot, s, sc;
        int unsigned d, cnt;
        out_item_t   r;
        slot = find_book(it.instrument_id);
        if (it.action == ACT_DEFINITION)
        begin
            d = (it.book_depth > MAX_DEPTH) ? MAX_DEPTH : 32'(it.book_depth);
            if (it.remove_instrument)
            begin
                if (slot >= 0)
                    bk_valid[slot] = 1'b0;
            end
            else if (slot < 0)
            begin
                for (s = 0; s < MAX_SECURITIES; s++)
                    if (!bk_valid[s])
                        break;
                if (s >= MAX_SECURITIES)
                begin
                    expected_results.push_back(make_result(STS_FULL, 1'b0));
                    return;
                end
                bk_valid[s] = 1'b1;
                bk_sec[s]   = it.instrument_id;
                bk_depth[s] = d;
                bk_cnt[2*s]   = 0;
                bk_cnt[2*s+1] = 0;
            end
            else
            begin
                bk_depth[slot] = d;
                for (int i = 0; i < 2; i++)
                    if (bk_cnt[2*slot+i] > d)
                        bk_cnt[2*slot+i] = d;
            end
            expected_results.push_back(make_result(STS_DEF_DONE, 1'b0));
            return;
        end
        if (it.entry_type == ET_RESET)
        begin
            foreach (bk_cnt[i])
                bk_cnt[i] = 0;
            expected_results.push_back(make_result(STS_RESET, 1'b0));
            return;
        end
        if (slot < 0 || it.entry_type > ET_TRADE)
        begin
            expected_results.push_back(make_result(STS_DISCARD, 1'b0));
            return;
        end
        if (it.entry_type == ET_TRADE)
        begin
            r = make_result(STS_TRADE, 1'b0);
            r.level_orders   = it.order_count;
            r.level_quantity = it.entry_quantity;
            r.level_price    = it.entry_price;
            expected_results.push_back(r);
            return;
        end
        if (!apply_book_update(slot, it))
        begin
            expected_results.push_back(make_result(STS_REJECTED, it.entry_type[0]));
            return;
        end
        sc  = slot * 2 + it.entry_type[0];
        cnt = bk_cnt[sc];
        if (cnt == 0)
        begin
            expected_results.push_back(make_result(STS_UPDATED, it.entry_type[0]));
            return;
        end
        for (int i = 0; i < cnt; i++)
        begin
            r = make_result(STS_UPDATED, it.entry_type[0]);
            r.level_index    = 4'(i + 1);
            r.level_orders   = bk_lvl[sc][i].orders;
            r.level_quantity = bk_lvl[sc][i].quantity;
            r.level_price    = bk_lvl[sc][i].price;
            r.last           = (i + 1 == cnt);
            expected_results.push_back(r);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Random gap: mostly short, now and then long
    function automatic int random_gap();
        int p;
        p = $urandom_range(99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // Security pool: small set so books fill up and get reused
    function automatic logic [31:0] pick_security();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF;
            default: return 32'h100 + $urandom_range(5);
        endcase
    endfunction

    function automatic in_item_t random_request();
        in_item_t it;
        int       p;
        it = '0;
        it.instrument_id     = pick_security();
        it.remove_instrument = 1'($urandom_range(1));
        it.order_count       = 31'($urandom);
        it.entry_quantity    = 31'($urandom);
        it.entry_price       = {$urandom, $urandom};
        p = $urandom_range(99);
        if (p < 10)
        begin
            it.action            = ACT_DEFINITION;
            it.remove_instrument = ($urandom_range(5) == 0);
            it.book_depth        = 8'(($urandom_range(7) == 0) ? $urandom
                                                                : $urandom_range(10));
            it.message_kind      = 2'($urandom);
            it.entry_type        = 3'($urandom);
            it.update_kind       = 3'($urandom);
            it.price_level       = 8'($urandom);
        end
        else
        begin
            it.action = ACT_BOOK;
            p = $urandom_range(99);
            if (p < 80)
            begin
                it.entry_type   = 3'($urandom_range(1));
                it.message_kind = 2'(($urandom_range(9) == 0) ? $urandom : $urandom_range(1));
                it.update_kind  = 3'(($urandom_range(9) == 0) ? $urandom : $urandom_range(4));
                if (it.update_kind < UK_DELTHRU && it.message_kind == MK_INCR)
                    it.update_kind = ($urandom_range(2) == 0) ? it.update_kind : UK_NEW;
                it.price_level  = 8'(($urandom_range(15) == 0) ? $urandom
                                                                : $urandom_range(11));
            end
            else
            begin
                it.entry_type   = ($urandom_range(9) == 0) ? ET_RESET
                                                           : 3'($urandom_range(7));
                it.message_kind = 2'($urandom);
                it.update_kind  = 3'($urandom);
                it.price_level  = 8'($urandom);
            end
        end
        return it;
    endfunction

    function automatic in_item_t book_entry(logic [31:0] sec, logic [2:0] et, logic [1:0] mk,
                                            logic [2:0] uk, logic [7:0] lvl);
        in_item_t it;
        it = '0;
        it.action         = ACT_BOOK;
        it.instrument_id  = sec;
        it.entry_type     = et;
        it.message_kind   = mk;
        it.update_kind    = uk;
        it.price_level    = lvl;
        it.order_count    = 31'($urandom);
        it.entry_quantity = 31'($urandom);
        it.entry_price    = {$urandom, $urandom};
        return it;
    endfunction

    function automatic in_item_t definition(logic [31:0] sec, logic rem, logic [7:0] depth);
        in_item_t it;
        it = '0;
        it.action            = ACT_DEFINITION;
        it.instrument_id     = sec;
        it.remove_instrument = rem;
        it.book_depth        = depth;
        return it;
    endfunction

    // Stimulus
    initial
    begin
        in_item_t it;
        stimulus_done = 1'b0;

        // Directed: extremes, every operation, special cases
        pending_requests.push_back(book_entry(32'h100, ET_BID, MK_INCR, UK_NEW, 8'd1)); // unknown
        pending_requests.push_back(definition(32'h100, 1'b0, 8'd255));                  // clamp
        pending_requests.push_back(definition(32'hFFFF_FFFF, 1'b0, 8'd0));              // depth 0
        pending_requests.push_back(book_entry(32'hFFFF_FFFF, ET_BID, MK_INCR, UK_NEW, 8'd1));
        pending_requests.push_back(book_entry(32'h100, ET_BID, MK_INCR, UK_NEW, 8'd1));
        pending_requests.push_back(book_entry(32'h100, ET_BID, MK_RECOVERY, UK_DELETE, 8'd5));
        pending_requests.push_back(book_entry(32'h100, ET_BID, MK_INCR, UK_NEW, 8'd10));
        pending_requests.push_back(book_entry(32'h100, ET_BID, MK_INCR, UK_CHANGE, 8'd2));
        pending_requests.push_back(book_entry(32'h100, ET_BID, MK_INCR, UK_DELETE, 8'd3));
        pending_requests.push_back(book_entry(32'h100, ET_BID, MK_INCR, UK_DELFROM, 8'd2));
        pending_requests.push_back(book_entry(32'h100, ET_BID, MK_INCR, UK_INVALID, 8'd1));
        pending_requests.push_back(book_entry(32'h100, ET_BID, MK_INCR, 3'd7, 8'd1));
        pending_requests.push_back(book_entry(32'h100, ET_BID, 2'd3, UK_NEW, 8'd1));
        pending_requests.push_back(book_entry(32'h100, ET_BID, MK_INCR, UK_NEW, 8'd0));
        pending_requests.push_back(book_entry(32'h100, ET_BID, MK_INCR, UK_NEW, 8'd255));
        pending_requests.push_back(book_entry(32'h100, ET_OFFER, MK_INCR, UK_CHANGE, 8'd1));
        pending_requests.push_back(book_entry(32'h100, ET_OFFER, MK_INCR, UK_DELTHRU, 8'd200));
        pending_requests.push_back(book_entry(32'h100, ET_TRADE, 2'd3, 3'd7, 8'hFF));
        pending_requests.push_back(book_entry(32'h100, 3'd7, MK_INCR, UK_NEW, 8'd1));   // other
        pending_requests.push_back(book_entry(32'h100, ET_IMPLIED, MK_INCR, UK_NEW, 8'd1));
        pending_requests.push_back(definition(32'h100, 1'b0, 8'd2));                    // truncate
        pending_requests.push_back(book_entry(32'h0, ET_RESET, 2'd3, 3'd7, 8'd0));
        pending_requests.push_back(definition(32'h1234, 1'b1, 8'd3));    // unknown removal
        pending_requests.push_back(definition(32'hFFFF_FFFF, 1'b1, 8'd0));

        // Fill the table to the full case, then free it again
        for (int i = 0; i < MAX_SECURITIES; i++)
            pending_requests.push_back(definition(32'h2000 + i, 1'b0, 8'd10));
        for (int i = 0; i < MAX_SECURITIES; i++)
            pending_requests.push_back(definition(32'h2000 + i, 1'b1, 8'd0));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            it = random_request();
            if (n % 40 == 0)
                it.order_count = 31'h7FFF_FFFF;
            pending_requests.push_back(it);
        end
        stimulus_done = 1'b1;
    end

    // Reset and end of run
    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (stimulus_done && pending_requests.size() == 0 && item_valid == 1'b0);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Driver
    int sent_count;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item        <= '0;
            item_valid  <= 1'b0;
            sender_hold <= 0;
            sent_count  <= 0;
            drain_req   <= 1'b0;
        end
        else if (!item_valid || item_ready)
        begin
            if (item_valid)
                sent_count <= sent_count + 1;
            if (sender_hold > 0)
            begin
                item_valid  <= 1'b0;
                sender_hold <= sender_hold - 1;
            end
            else if (drain_req)
            begin
                item_valid <= 1'b0;
                if (expected_results.size() == 0 && !(item_valid && item_ready))
                    drain_req <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                item        <= pending_requests.pop_front();
                item_valid  <= 1'b1;
                sender_hold <= random_gap();
                if (sent_count == 250)
                    drain_req <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Predictor on acceptance
    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
            predict_book_results(item);
    end

    // Receiver stall and result check
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            result_ready   <= 1'b0;
            receiver_hold  <= 0;
            long_stall_req <= 1'b0;
            error_count    = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", 64'(result.status), 64'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status != want.status)
                        report_mismatch("status", result.status, want.status);
                    if (result.side != want.side)
                        report_mismatch("side", result.side, want.side);
                    if (result.level_index != want.level_index)
                        report_mismatch("level_index", result.level_index, want.level_index);
                    if (result.level_orders != want.level_orders)
                        report_mismatch("level_orders", result.level_orders, want.level_orders);
                    if (result.level_quantity != want.level_quantity)
                        report_mismatch("level_quantity", result.level_quantity,
                                        want.level_quantity);
                    if (result.level_price != want.level_price)
                        report_mismatch("level_price", result.level_price, want.level_price);
                    if (result.last != want.last)
                        report_mismatch("last", result.last, want.last);
                end
            end
            // one long hold while the sender keeps offering
            if (sent_count == 120 && !long_stall_req)
            begin
                long_stall_req <= 1'b1;
                receiver_hold  <= 400;
                result_ready   <= 1'b0;
            end
            else if (receiver_hold > 0)
            begin
                receiver_hold <= receiver_hold - 1;
                result_ready  <= 1'b0;
            end
            else if (sent_count > 300 && sent_count < 340)
                result_ready <= 1'b1;
            else
            begin
                receiver_hold <= random_gap();
                result_ready  <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no handshake on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/plb_pkg.sv
rtl/plb_dp.sv
rtl/plb_ctrl.sv
rtl/price_level_book_builder.sv
dv/testbench.sv
